>>> design/snel_pkg.sv
// Shared constants, codes and controller/datapath interface types of the symbol name expander.
`timescale 1ns / 1ps
package snel_pkg;

  localparam int unsigned TOK_BYTES     = 4096;
  localparam int unsigned TOK_AW        = $clog2(TOK_BYTES);
  localparam int unsigned NUM_CODES     = 256;
  localparam int unsigned NAME_LEN      = 128;
  localparam int unsigned NAME_AW       = $clog2(NAME_LEN);
  localparam int unsigned MAX_SYMBOLS   = 1024;
  localparam int unsigned SYM_AW        = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int unsigned MAX_TOKEN_LEN = 32;
  localparam int unsigned TOKI_W        = $clog2(MAX_TOKEN_LEN);

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned ADDR_W   = 12;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned CODE_W   = 8;
  localparam int unsigned CNT_W    = 11;
  localparam int unsigned SYMNUM_W = 10;

  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 88;
  localparam int unsigned OUT_TUSER_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_TOK_BYTE  = 3'd0,
    CMD_TOK_START = 3'd1,
    CMD_NAME_CHAR = 3'd2,
    CMD_SYM_ADDR  = 3'd3,
    CMD_STREAM    = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_TOK_RD,
    S_TOK_CHK,
    S_END_RD,
    S_END_OUT,
    S_DONE_OUT
  } ctl_state_e;

  typedef struct packed {
    logic mem_wr;
    logic len_ld;
    logic ts_rd;
    logic tok_init;
    logic tok_rd;
    logic tok_step;
    logic code_dec;
    logic end_rd;
    logic end_emit;
    logic done_emit;
  } ctrl_t;

  typedef struct packed {
    logic is_stream;
    logic byte_zero;
    logic stream_done;
    logic awaiting;
    logic chr_zero;
    logic chr_emit;
    logic tok_last;
    logic codes_last;
    logic out_free;
  } stat_t;

endpackage

>>> design/snel_ctrl.sv
// Sequencing state machine of the symbol name expander.
`timescale 1ns / 1ps
module snel_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  snel_pkg::stat_t   stat_i,
  output snel_pkg::ctrl_t   ctrl_o
);

  snel_pkg::ctl_state_e state_q, state_d;
  logic acc;
  logic step_ok;

  // Hold a character step while the output register is still occupied.
  assign step_ok = !stat_i.chr_emit || stat_i.out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= snel_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      snel_pkg::S_IDLE: begin
        if (in_valid_i && stat_i.is_stream) begin
          if (stat_i.stream_done) begin
            state_d = snel_pkg::S_DONE_OUT;
          end else if (stat_i.awaiting) begin
            if (stat_i.byte_zero) begin
              state_d = snel_pkg::S_END_RD;
            end
          end else begin
            state_d = snel_pkg::S_START;
          end
        end
      end
      snel_pkg::S_START:  state_d = snel_pkg::S_TOK_RD;
      snel_pkg::S_TOK_RD: state_d = snel_pkg::S_TOK_CHK;
      snel_pkg::S_TOK_CHK: begin
        if (step_ok) begin
          if (stat_i.chr_zero || stat_i.tok_last) begin
            state_d = stat_i.codes_last ? snel_pkg::S_END_RD : snel_pkg::S_IDLE;
          end else begin
            state_d = snel_pkg::S_TOK_RD;
          end
        end
      end
      snel_pkg::S_END_RD: state_d = snel_pkg::S_END_OUT;
      snel_pkg::S_END_OUT: begin
        if (stat_i.out_free) begin
          state_d = snel_pkg::S_IDLE;
        end
      end
      snel_pkg::S_DONE_OUT: begin
        if (stat_i.out_free) begin
          state_d = snel_pkg::S_IDLE;
        end
      end
      default: state_d = snel_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == snel_pkg::S_IDLE);
    acc        = in_ready_o && in_valid_i;
    ctrl_o          = '0;
    ctrl_o.mem_wr   = acc && !stat_i.is_stream;
    ctrl_o.len_ld   = acc && stat_i.is_stream && !stat_i.stream_done && stat_i.awaiting
                      && !stat_i.byte_zero;
    ctrl_o.ts_rd    = acc && stat_i.is_stream && !stat_i.stream_done && !stat_i.awaiting;
    ctrl_o.tok_init = (state_q == snel_pkg::S_START);
    ctrl_o.tok_rd   = (state_q == snel_pkg::S_TOK_RD);
    ctrl_o.tok_step = (state_q == snel_pkg::S_TOK_CHK) && step_ok;
    ctrl_o.code_dec = ctrl_o.tok_step && (stat_i.chr_zero || stat_i.tok_last);
    ctrl_o.end_rd   = (state_q == snel_pkg::S_END_RD);
    ctrl_o.end_emit = (state_q == snel_pkg::S_END_OUT) && stat_i.out_free;
    ctrl_o.done_emit = (state_q == snel_pkg::S_DONE_OUT) && stat_i.out_free;
  end

endmodule

>>> design/snel_dpath.sv
// Stores, symbol tracking registers and output register of the symbol name expander.
`timescale 1ns / 1ps
module snel_dpath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [snel_pkg::CNT_W-1:0]       cfg_data_i,
  input  logic [snel_pkg::CMD_W-1:0]       cmd_i,
  input  logic [snel_pkg::ADDR_W-1:0]      addr_i,
  input  logic [snel_pkg::DATA_W-1:0]      data_i,
  input  logic                             out_ready_i,
  input  snel_pkg::ctrl_t                  ctrl_i,
  output snel_pkg::stat_t                  stat_o,
  output logic                             out_valid_o,
  output logic [snel_pkg::CHAR_W-1:0]      out_char_o,
  output logic                             char_valid_o,
  output logic                             symbol_end_o,
  output logic [snel_pkg::SYMNUM_W-1:0]    symbol_number_o,
  output logic                             matched_o,
  output logic                             search_done_o,
  output logic [snel_pkg::DATA_W-1:0]      found_address_o
);

  // Stores
  logic [snel_pkg::CHAR_W-1:0] tb_mem [snel_pkg::TOK_BYTES];
  logic [snel_pkg::TOK_AW-1:0] ts_mem [snel_pkg::NUM_CODES];
  logic [snel_pkg::CHAR_W-1:0] tn_mem [snel_pkg::NAME_LEN];
  logic [snel_pkg::DATA_W-1:0] sa_mem [snel_pkg::MAX_SYMBOLS];

  logic [snel_pkg::CHAR_W-1:0] tb_rdata_q;
  logic [snel_pkg::TOK_AW-1:0] ts_rdata_q;
  logic [snel_pkg::CHAR_W-1:0] tn_rdata_q;
  logic [snel_pkg::DATA_W-1:0] sa_rdata_q;

  // Symbol tracking
  logic [snel_pkg::CODE_W-1:0]  codes_left_q;
  logic                         awaiting_q;
  logic                         type_skipped_q;
  logic [snel_pkg::NAME_AW-1:0] np_q;
  logic                         mismatch_q;
  logic [snel_pkg::CNT_W-1:0]   cur_q;
  logic                         found_q;
  logic [snel_pkg::DATA_W-1:0]  found_addr_q;
  logic [snel_pkg::CNT_W-1:0]   count_q;
  logic [snel_pkg::TOK_AW-1:0]  ptr_q;
  logic [snel_pkg::TOKI_W-1:0]  tok_i_q;
  logic                         out_valid_q;

  logic [snel_pkg::CODE_W-1:0]  in_byte;
  logic                         np_full;
  logic                         match;
  logic                         cur_in_range;
  logic [snel_pkg::DATA_W-1:0]  hit_addr;
  logic                         last_sym;
  logic                         emit_chr;
  logic                         out_free;

  assign in_byte      = data_i[snel_pkg::CODE_W-1:0];
  assign np_full      = (np_q == snel_pkg::NAME_AW'(snel_pkg::NAME_LEN - 1));
  assign match        = !mismatch_q && (tn_rdata_q == '0);
  assign cur_in_range = (32'(cur_q) < snel_pkg::MAX_SYMBOLS);
  assign hit_addr     = cur_in_range ? sa_rdata_q : '0;
  assign last_sym     = ({1'b0, cur_q} + (snel_pkg::CNT_W+1)'(1)) >= {1'b0, count_q};
  assign out_free     = !out_valid_q || out_ready_i;
  assign emit_chr     = ctrl_i.tok_step && stat_o.chr_emit;

  always_comb begin
    stat_o.is_stream   = (cmd_i == snel_pkg::CMD_STREAM);
    stat_o.byte_zero   = (in_byte == '0);
    stat_o.stream_done = found_q || (cur_q >= count_q);
    stat_o.awaiting    = awaiting_q;
    stat_o.chr_zero    = (tb_rdata_q == '0);
    stat_o.chr_emit    = (tb_rdata_q != '0) && type_skipped_q && !np_full;
    stat_o.tok_last    = (tok_i_q == snel_pkg::TOKI_W'(snel_pkg::MAX_TOKEN_LEN - 1));
    stat_o.codes_last  = (codes_left_q == snel_pkg::CODE_W'(1));
    stat_o.out_free    = out_free;
  end

  // Token byte table
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mem_wr && cmd_i == snel_pkg::CMD_TOK_BYTE
        && 32'(addr_i) < snel_pkg::TOK_BYTES) begin
      tb_mem[snel_pkg::TOK_AW'(addr_i)] <= data_i[snel_pkg::CHAR_W-1:0];
    end
    if (ctrl_i.tok_rd) begin
      tb_rdata_q <= tb_mem[ptr_q];
    end
  end

  // Token start per code byte, kept modulo the table size
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mem_wr && cmd_i == snel_pkg::CMD_TOK_START
        && 32'(addr_i) < snel_pkg::NUM_CODES) begin
      ts_mem[addr_i[snel_pkg::CODE_W-1:0]] <= data_i[snel_pkg::TOK_AW-1:0];
    end
    if (ctrl_i.ts_rd) begin
      ts_rdata_q <= ts_mem[in_byte];
    end
  end

  // Target name
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mem_wr && cmd_i == snel_pkg::CMD_NAME_CHAR
        && 32'(addr_i) < snel_pkg::NAME_LEN) begin
      tn_mem[snel_pkg::NAME_AW'(addr_i)] <= data_i[snel_pkg::CHAR_W-1:0];
    end
    if (ctrl_i.tok_rd || ctrl_i.end_rd) begin
      tn_rdata_q <= tn_mem[np_q];
    end
  end

  // Symbol addresses
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mem_wr && cmd_i == snel_pkg::CMD_SYM_ADDR
        && 32'(addr_i) < snel_pkg::MAX_SYMBOLS) begin
      sa_mem[snel_pkg::SYM_AW'(addr_i)] <= data_i;
    end
    if (ctrl_i.end_rd) begin
      sa_rdata_q <= sa_mem[snel_pkg::SYM_AW'(cur_q)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_left_q   <= '0;
      awaiting_q     <= 1'b1;
      type_skipped_q <= 1'b0;
      np_q           <= '0;
      mismatch_q     <= 1'b0;
      cur_q          <= '0;
      found_q        <= 1'b0;
      found_addr_q   <= '0;
      count_q        <= '0;
      ptr_q          <= '0;
      tok_i_q        <= '0;
    end else begin
      if (cfg_valid_i) begin
        count_q <= cfg_data_i;
      end
      if (ctrl_i.len_ld) begin
        codes_left_q <= in_byte;
        awaiting_q   <= 1'b0;
      end
      if (ctrl_i.tok_init) begin
        ptr_q   <= ts_rdata_q;
        tok_i_q <= '0;
      end
      if (ctrl_i.tok_step && !stat_o.chr_zero) begin
        ptr_q   <= ptr_q + snel_pkg::TOK_AW'(1);
        tok_i_q <= tok_i_q + snel_pkg::TOKI_W'(1);
        if (!type_skipped_q) begin
          type_skipped_q <= 1'b1;
        end else if (!np_full) begin
          np_q <= np_q + snel_pkg::NAME_AW'(1);
          if (tn_rdata_q != tb_rdata_q) begin
            mismatch_q <= 1'b1;
          end
        end else begin
          // Name overflow: drop the character, the symbol can no longer match
          mismatch_q <= 1'b1;
        end
      end
      if (ctrl_i.code_dec) begin
        codes_left_q <= codes_left_q - snel_pkg::CODE_W'(1);
      end
      if (ctrl_i.end_emit) begin
        if (match) begin
          found_q      <= 1'b1;
          found_addr_q <= hit_addr;
        end else begin
          cur_q <= cur_q + snel_pkg::CNT_W'(1);
        end
        codes_left_q   <= '0;
        awaiting_q     <= 1'b1;
        type_skipped_q <= 1'b0;
        np_q           <= '0;
        mismatch_q     <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_chr || ctrl_i.end_emit || ctrl_i.done_emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_chr) begin
      out_char_o      <= tb_rdata_q;
      char_valid_o    <= 1'b1;
      symbol_end_o    <= 1'b0;
      symbol_number_o <= cur_q[snel_pkg::SYMNUM_W-1:0];
      matched_o       <= 1'b0;
      search_done_o   <= 1'b0;
      found_address_o <= '0;
    end else if (ctrl_i.end_emit) begin
      out_char_o      <= '0;
      char_valid_o    <= 1'b0;
      symbol_end_o    <= 1'b1;
      symbol_number_o <= cur_q[snel_pkg::SYMNUM_W-1:0];
      matched_o       <= match;
      search_done_o   <= match || last_sym;
      found_address_o <= match ? hit_addr : '0;
    end else if (ctrl_i.done_emit) begin
      out_char_o      <= '0;
      char_valid_o    <= 1'b0;
      symbol_end_o    <= 1'b0;
      symbol_number_o <= cur_q[snel_pkg::SYMNUM_W-1:0];
      matched_o       <= 1'b0;
      search_done_o   <= 1'b1;
      found_address_o <= found_q ? found_addr_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_emit_into_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_chr || ctrl_i.end_emit || ctrl_i.done_emit) |-> out_free)
    else $error("result written over a pending transaction");
  a_found_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |=> found_q)
    else $error("match flag cleared during search");
  a_tok_in_symbol : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.tok_rd || ctrl_i.ts_rd) |-> !awaiting_q)
    else $error("token expansion while awaiting a length byte");
  a_end_restarts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.end_emit |=> (awaiting_q && np_q == '0 && !mismatch_q))
    else $error("symbol state not restarted after end marker");
`endif

endmodule

>>> design/symbol_name_expander_lookup.sv
// Top level of the symbol name expander: stream ports, configuration port and packing.
`timescale 1ns / 1ps
// Usage:
//   Input transactions carry a command in s_axis_tuser_i and a table position and value
//   in s_axis_tdata_i. Load commands fill the token byte table, the token start table,
//   the target name and the symbol address store; each gives no result.
//   Stream bytes then carry the compressed names: a length byte per symbol, then its code
//   bytes. Each code byte gives one result per name character; the last code byte of a
//   symbol (or a zero length byte) also gives an end-marker result, flagged by tlast,
//   carrying the match flag, the search state and the found address.
//   A code byte occupies the block while its token is read (at most 32 bytes): one token
//   table read and one name compare per character on the single read port of each store.
//   An end marker adds a read of the target name and of the symbol address store.
//   Once a match is found or symbol_count symbols have passed, each stream byte gives a
//   single done result.
//   The configuration channel sets symbol_count; write it only while the block is idle.
//   Reset clears the search state and symbol_count; the stores are undefined until loaded.
//   Results sit in an output register; while the receiver stalls the block holds the next
//   result and stops taking stream bytes.
module symbol_name_expander_lookup (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [snel_pkg::CNT_W-1:0]          cfg_data_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // addr [11:0], data [75:12], zero fill above
  input  logic [snel_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // cmd [2:0]
  input  logic [snel_pkg::CMD_W-1:0]          s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // out_char [7:0], symbol_number [17:8], found_address [81:18], zero fill above
  output logic [snel_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  // char_valid [0], matched [1], search_done [2]
  output logic [snel_pkg::OUT_TUSER_W-1:0]    m_axis_tuser_o,
  // symbol_end
  output logic                                m_axis_tlast_o
);

  snel_pkg::ctrl_t ctrl;
  snel_pkg::stat_t stat;

  logic [snel_pkg::CHAR_W-1:0]   out_char;
  logic                          char_valid;
  logic                          matched;
  logic                          search_done;
  logic [snel_pkg::SYMNUM_W-1:0] symbol_number;
  logic [snel_pkg::DATA_W-1:0]   found_address;

  assign cfg_ready_o = 1'b1;

  snel_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  snel_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (s_axis_tuser_i),
    .addr_i          (s_axis_tdata_i[snel_pkg::ADDR_W-1:0]),
    .data_i          (s_axis_tdata_i[snel_pkg::ADDR_W+snel_pkg::DATA_W-1:snel_pkg::ADDR_W]),
    .out_ready_i     (m_axis_tready_i),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .out_valid_o     (m_axis_tvalid_o),
    .out_char_o      (out_char),
    .char_valid_o    (char_valid),
    .symbol_end_o    (m_axis_tlast_o),
    .symbol_number_o (symbol_number),
    .matched_o       (matched),
    .search_done_o   (search_done),
    .found_address_o (found_address)
  );

  assign m_axis_tdata_o = {6'd0, found_address, symbol_number, out_char};
  assign m_axis_tuser_o = {search_done, matched, char_valid};

endmodule

>>> tb/sv/symbol_name_expander_lookup_tb.sv
// Self-checking testbench for the symbol name expander: table loads, name stream, lookup.
`timescale 1ns / 1ps
module symbol_name_expander_lookup_tb;
  import snel_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = CMD_STREAM + 3'd1;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;
  localparam int unsigned SLOT_BYTES     = TOK_BYTES / NUM_CODES;
  localparam int unsigned LONG_REGION    = TOK_BYTES - 8 * SLOT_BYTES;
  localparam int unsigned FIRST_LONG     = NUM_CODES - 8;
  localparam int unsigned WRAP_CODE      = NUM_CODES - 1;
  localparam int unsigned EMPTY_CODE     = 240;
  localparam int unsigned SETTLE_CYCLES  = 100;
  localparam int unsigned DRAIN_LIMIT    = 200000;

  typedef bit [7:0] char_q_t[$];

  typedef struct packed {
    logic [CHAR_W-1:0]   ch;
    logic                char_valid;
    logic                sym_end;
    logic [SYMNUM_W-1:0] sym_num;
    logic                matched;
    logic                done;
    logic [DATA_W-1:0]   found_addr;
  } lookup_result_t;

  // Tracks the tables and search state; predicts the expected name characters and markers.
  class name_lookup_scoreboard;
    bit [7:0]        tok_bytes[TOK_BYTES];
    bit [TOK_AW-1:0] tok_start[NUM_CODES];
    bit [7:0]        target[NAME_LEN];
    bit [63:0]       sym_addr[MAX_SYMBOLS];
    bit [7:0]        codes_left;
    bit              wait_len = 1'b1;
    bit              type_seen;
    bit              mismatch;
    bit              found;
    bit [CNT_W-1:0]  cur_sym;
    int unsigned     name_pos;
    int unsigned     sym_limit;
    lookup_result_t  pending[$];
    int unsigned     errors;
    int unsigned     checked;
    int unsigned     symbols_closed;

    task report(input string what);
      errors++;
      if (errors <= 40) $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    function char_q_t token_chars(input bit [7:0] code);
      char_q_t     chars;
      bit [7:0]    c;
      int unsigned pos;
      pos = tok_start[code];
      for (int unsigned i = 0; i < MAX_TOKEN_LEN; i++) begin
        c = tok_bytes[(pos + i) % TOK_BYTES];
        if (c == 8'd0) break;
        chars.push_back(c);
      end
      return chars;
    endfunction

    function bit [63:0] addr_now();
      return (cur_sym < MAX_SYMBOLS) ? sym_addr[cur_sym[SYM_AW-1:0]] : 64'd0;
    endfunction

    function void push(bit [7:0] ch, bit cv, bit se, bit mt, bit dn, bit [63:0] fa);
      lookup_result_t r;
      r.ch         = ch;
      r.char_valid = cv;
      r.sym_end    = se;
      r.sym_num    = cur_sym[SYMNUM_W-1:0];
      r.matched    = mt;
      r.done       = dn;
      r.found_addr = fa;
      pending.push_back(r);
    endfunction

    function void close_symbol();
      bit hit;
      hit = !mismatch && name_pos < NAME_LEN && target[name_pos] == 8'd0;
      if (hit) begin
        found = 1'b1;
        push(8'd0, 1'b0, 1'b1, 1'b1, 1'b1, addr_now());
      end else begin
        push(8'd0, 1'b0, 1'b1, 1'b0, (int'(cur_sym) + 1 >= int'(sym_limit)), 64'd0);
        cur_sym = cur_sym + 1'b1;
      end
      symbols_closed++;
      codes_left = 8'd0;
      wait_len   = 1'b1;
      type_seen  = 1'b0;
      name_pos   = 0;
      mismatch   = 1'b0;
    endfunction

    function void stream_byte(bit [7:0] b);
      char_q_t chars;
      if (found || cur_sym >= sym_limit) begin
        push(8'd0, 1'b0, 1'b0, 1'b0, 1'b1, found ? addr_now() : 64'd0);
        return;
      end
      if (wait_len) begin
        if (b == 8'd0) begin
          close_symbol();
        end else begin
          codes_left = b;
          wait_len   = 1'b0;
        end
        return;
      end
      chars = token_chars(b);
      foreach (chars[i]) begin
        if (!type_seen) begin
          type_seen = 1'b1;
        end else if (name_pos + 1 < NAME_LEN) begin
          if (target[name_pos] != chars[i]) mismatch = 1'b1;
          name_pos++;
          push(chars[i], 1'b1, 1'b0, 1'b0, 1'b0, 64'd0);
        end else begin
          mismatch = 1'b1;
        end
      end
      codes_left = codes_left - 8'd1;
      if (codes_left == 8'd0) close_symbol();
    endfunction

    function void note_input(bit [CMD_W-1:0] cmd, bit [ADDR_W-1:0] a, bit [DATA_W-1:0] d);
      case (cmd)
        CMD_TOK_BYTE:  tok_bytes[a] = d[7:0];
        CMD_TOK_START: if (a < NUM_CODES) tok_start[a[7:0]] = d[TOK_AW-1:0];
        CMD_NAME_CHAR: if (a < NAME_LEN) target[a[NAME_AW-1:0]] = d[7:0];
        CMD_SYM_ADDR:  if (a < MAX_SYMBOLS) sym_addr[a[SYM_AW-1:0]] = d;
        CMD_STREAM:    stream_byte(d[7:0]);
        default: ;
      endcase
    endfunction

    task check_result(input lookup_result_t got);
      lookup_result_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result char %02h end %0b done %0b",
                         got.ch, got.sym_end, got.done));
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.ch !== want.ch)
        report($sformatf("out_char %02h, want %02h", got.ch, want.ch));
      if (got.char_valid !== want.char_valid)
        report($sformatf("char_valid %0b, want %0b", got.char_valid, want.char_valid));
      if (got.sym_end !== want.sym_end)
        report($sformatf("symbol_end %0b, want %0b", got.sym_end, want.sym_end));
      if (got.sym_num !== want.sym_num)
        report($sformatf("symbol_number %0d, want %0d", got.sym_num, want.sym_num));
      if (got.matched !== want.matched)
        report($sformatf("matched %0b, want %0b", got.matched, want.matched));
      if (got.done !== want.done)
        report($sformatf("search_done %0b, want %0b", got.done, want.done));
      if (got.found_addr !== want.found_addr)
        report($sformatf("found_address %016h, want %016h", got.found_addr, want.found_addr));
    endtask
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CNT_W-1:0]       cfg_data_i;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i;
  logic [CMD_W-1:0]       s_axis_tuser_i;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic [OUT_TUSER_W-1:0] m_axis_tuser_o;
  logic                   m_axis_tlast_o;

  name_lookup_scoreboard lookup_sb = new();
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned accepted;
  int unsigned stream_items;

  symbol_name_expander_lookup DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Sample result transactions, then pick the next ready value.
  always @(posedge clk_i) begin
    lookup_result_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.ch         = m_axis_tdata_o[7:0];
      got.sym_num    = m_axis_tdata_o[17:8];
      got.found_addr = m_axis_tdata_o[81:18];
      got.char_valid = m_axis_tuser_o[0];
      got.matched    = m_axis_tuser_o[1];
      got.done       = m_axis_tuser_o[2];
      got.sym_end    = m_axis_tlast_o;
      lookup_sb.check_result(got);
    end
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic bit [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] a,
                           input logic [DATA_W-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(IN_TDATA_W - ADDR_W - DATA_W){1'b0}}, d, a};
    s_axis_tuser_i  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    lookup_sb.note_input(cmd, a, d);
    accepted++;
  endtask

  task automatic send_stream(input bit [7:0] b);
    bit [63:0] d;
    d       = rand64();
    d[7:0]  = b;
    stream_items++;
    send_item(CMD_STREAM, ADDR_W'($urandom), d);
  endtask

  task automatic send_symbol(input char_q_t codes);
    send_stream(8'(codes.size()));
    foreach (codes[i]) send_stream(codes[i]);
  endtask

  task automatic load_name(input char_q_t name, input bit [7:0] tail);
    foreach (name[i]) send_item(CMD_NAME_CHAR, ADDR_W'(i), {rand64() >> 8, name[i]});
    send_item(CMD_NAME_CHAR, ADDR_W'(name.size()), {rand64() >> 8, tail});
  endtask

  // Expanded name of a code list as the block would keep it: type character dropped.
  function automatic char_q_t expand_name(input char_q_t codes);
    char_q_t name;
    foreach (codes[i]) name = {name, lookup_sb.token_chars(codes[i])};
    if (name.size() > 0) void'(name.pop_front());
    return name;
  endfunction

  task automatic drain();
    int unsigned waited;
    s_axis_tvalid_i <= 1'b0;
    waited = 0;
    while (lookup_sb.pending.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (lookup_sb.pending.size() != 0) begin
      lookup_sb.report($sformatf("%0d expected results never arrived",
                                 lookup_sb.pending.size()));
      lookup_sb.pending.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_count(input int unsigned count);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= CNT_W'(count);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    lookup_sb.sym_limit = count;
  endtask

  // Mostly well-formed symbols; some table reloads, unused commands and stray bytes.
  task automatic run_random(input int unsigned n_items);
    int unsigned goal;
    int unsigned pick;
    int unsigned len;
    char_q_t     codes;
    bit [63:0]   d;
    goal = stream_items + n_items;
    while (stream_items < goal) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        case ($urandom_range(4))
          0: send_item(CMD_TOK_BYTE, ADDR_W'($urandom), rand64());
          1: send_item(CMD_TOK_START, ADDR_W'($urandom), rand64());
          2: begin
            d = rand64();
            if (d[7:0] == 8'd0) d[0] = 1'b1;
            send_item(CMD_NAME_CHAR, ADDR_W'($urandom), d);
          end
          3: send_item(CMD_SYM_ADDR, ADDR_W'($urandom), rand64());
          default: send_item(CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST)),
                             ADDR_W'($urandom), rand64());
        endcase
      end else if (pick < 15) begin
        send_stream(8'($urandom));
      end else begin
        pick = $urandom_range(99);
        len  = (pick < 5) ? 0 : (pick < 10) ? $urandom_range(6, 10) : $urandom_range(1, 4);
        codes.delete();
        repeat (len) begin
          if ($urandom_range(99) < 80) codes.push_back(8'($urandom_range(0, FIRST_LONG - 1)));
          else codes.push_back(8'($urandom));
        end
        send_symbol(codes);
      end
    end
  endtask

  initial begin
    bit [7:0]        tok_img[TOK_BYTES];
    bit [TOK_AW-1:0] start_img[NUM_CODES];
    int unsigned     len;
    char_q_t         codes;
    char_q_t         name;
    rst_ni          <= 1'b0;
    cfg_valid_i     <= 1'b0;
    cfg_data_i      <= '0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= CMD_TOK_BYTE;
    m_axis_tready_i <= 1'b0;
    send_idle_pct   = 32;
    recv_stall_pct  = 70;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_count(0);

    // Short zero-terminated tokens in 16-byte slots, one empty token, then a run of
    // non-zero bytes for tokens cut at the read limit; the last code wraps to address 0.
    for (int c = 0; c < NUM_CODES; c++) begin
      len = (c == EMPTY_CODE) ? 0 : 1 + c % 12;
      for (int j = 0; j < SLOT_BYTES; j++) begin
        if (c >= FIRST_LONG || j < len) tok_img[c * SLOT_BYTES + j] = 8'($urandom_range(1, 255));
        else if (j == len) tok_img[c * SLOT_BYTES + j] = 8'd0;
        else tok_img[c * SLOT_BYTES + j] = 8'($urandom);
      end
      if (c == WRAP_CODE) start_img[c] = TOK_AW'(TOK_BYTES - 6);
      else if (c >= FIRST_LONG) start_img[c] = TOK_AW'(LONG_REGION + (c - FIRST_LONG) * 8);
      else start_img[c] = TOK_AW'(c * SLOT_BYTES);
    end
    tok_img[0] = 8'hFF;
    tok_img[1] = 8'd0;
    for (int i = 0; i < TOK_BYTES; i++)
      send_item(CMD_TOK_BYTE, ADDR_W'(i), {rand64() >> 8, tok_img[i]});
    // Upper bits of a start value are beyond the table and must be dropped.
    for (int c = 0; c < NUM_CODES; c++)
      send_item(CMD_TOK_START, ADDR_W'(c), {rand64() >> TOK_AW, start_img[c]});
    for (int i = 0; i < NAME_LEN; i++)
      send_item(CMD_NAME_CHAR, ADDR_W'(i), {rand64() >> 8, 8'($urandom_range(1, 255))});
    for (int i = 0; i < MAX_SYMBOLS; i++)
      send_item(CMD_SYM_ADDR, ADDR_W'(i), rand64());

    // Search already over with a zero count; unused commands; loads beyond their store.
    send_stream(8'h00);
    send_stream(8'hFF);
    for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++)
      send_item(CMD_W'(c), ADDR_W'($urandom), rand64());
    send_item(CMD_TOK_START, ADDR_W'(NUM_CODES), rand64());
    send_item(CMD_TOK_START, {ADDR_W{1'b1}}, rand64());
    send_item(CMD_NAME_CHAR, ADDR_W'(NAME_LEN), 64'd0);
    send_item(CMD_SYM_ADDR, ADDR_W'(MAX_SYMBOLS), {64{1'b1}});
    drain();

    // Empty symbol, then a name too long to keep that exhausts a count of two.
    write_count(2);
    codes.delete();
    send_symbol(codes);
    repeat (5) codes.push_back(8'(FIRST_LONG + 2));
    send_symbol(codes);
    send_stream(8'($urandom));
    drain();

    write_count(MAX_SYMBOLS);
    codes = '{8'(WRAP_CODE), 8'd0};
    send_symbol(codes);
    codes = '{8'(EMPTY_CODE)};
    send_symbol(codes);
    // Name equal to the target prefix, but no terminator follows in the target.
    codes = '{8'd1, 8'd2};
    load_name(expand_name(codes), 8'h5A);
    send_symbol(codes);

    run_random(70);
    drain();

    send_idle_pct  = 70;
    recv_stall_pct = 32;
    write_count(lookup_sb.cur_sym + 500);
    run_random(70);
    drain();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_count(MAX_SYMBOLS);
    run_random(70);
    // Close the search with a matching symbol, then check the reported address.
    codes = '{8'($urandom_range(0, EMPTY_CODE - 1)), 8'($urandom_range(0, EMPTY_CODE - 1))};
    drain();
    name = expand_name(codes);
    load_name(name, 8'd0);
    send_symbol(codes);
    send_stream(8'($urandom));
    send_item(CMD_SYM_ADDR, ADDR_W'(lookup_sb.cur_sym), rand64());
    send_stream(8'($urandom));
    drain();

    $display("ran %0d input transactions (%0d stream bytes); checked %0d results",
             accepted, stream_items, lookup_sb.checked);
    $display("%0d symbols closed, final symbol %0d, match found: %0b",
             lookup_sb.symbols_closed, lookup_sb.cur_sym, lookup_sb.found);
    if (lookup_sb.errors == 0) begin
      $display("symbol_name_expander_lookup regression: pass");
    end else begin
      $display("symbol_name_expander_lookup regression: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", lookup_sb.pending.size());
    $display("symbol_name_expander_lookup regression: fail");
    $finish;
  end

endmodule
